// ----- rtl/flsa_pkg.sv -----
// ----------------------------------------------------------------------------
// flsa_pkg
// Shared types and constants for the free list stack allocator.
// ----------------------------------------------------------------------------
package flsa_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESTORE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_DOUBLE   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  // Per-cycle action of every stack cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_LOAD = 2'd3
  } cell_op_t;

endpackage

// ----- rtl/flsa_cell.sv -----
// ----------------------------------------------------------------------------
// flsa_cell
// One slot of the shifting free stack. Cell 0 is the top of the stack.
// ----------------------------------------------------------------------------
module flsa_cell (
  input  logic                        clk,
  input  flsa_pkg::cell_op_t          op,
  input  logic [flsa_pkg::IDX_W-1:0]  load_value,
  input  logic [flsa_pkg::IDX_W-1:0]  above,
  input  logic [flsa_pkg::IDX_W-1:0]  below,
  output logic [flsa_pkg::IDX_W-1:0]  value
);
  import flsa_pkg::*;

  // push moves entries away from the top, pop moves them toward it
  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH: value <= above;
      CELL_POP:  value <= below;
      CELL_LOAD: value <= load_value;
      default:   value <= value;
    endcase
  end

endmodule

// ----- rtl/free_list_stack_allocator_core.sv -----
// ----------------------------------------------------------------------------
// free_list_stack_allocator_core
// Fixed-block pool allocator with a free-index stack; out status comes from the stack.
// ----------------------------------------------------------------------------
// Every command is accepted while start is high and its result appears on the
// cycle after start, marked by done. busy stays low, so a new command may be
// issued on every cycle, restore included (all stack cells load in parallel).
// The free stack is a row of cells that shift by one slot on each successful acquire or
// release, so the top entry is always at cell 0. An item counts as out when
// its index is not among the live stack entries. The result is shown for one
// cycle only and must be captured then. A pool_size write takes effect at the
// next restore command.
module free_list_stack_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [flsa_pkg::CMD_W-1:0]    command,
  input  logic [flsa_pkg::IDX_W-1:0]    item_index,
  input  logic                          cfg_we,
  input  logic [flsa_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          done,
  output logic [flsa_pkg::STATUS_W-1:0] status,
  output logic [flsa_pkg::IDX_W-1:0]    granted_index,
  output logic [flsa_pkg::CNT_W-1:0]    available
);
  import flsa_pkg::*;

  logic [CNT_W-1:0]     pool_size;
  logic [CNT_W-1:0]     active_size;
  logic [CNT_W-1:0]     active_size_next;
  logic [CNT_W-1:0]     stack_top;
  logic [CNT_W-1:0]     stack_top_next;
  logic [MAX_ITEMS-1:0] on_stack;
  logic                 item_free;
  status_t              status_next;
  logic [IDX_W-1:0]     grant_next;
  cell_op_t             cell_op;
  logic [CNT_W-1:0]     clamp_size;
  logic [CNT_W-1:0]     load_size;
  logic [IDX_W-1:0]     cell_q [MAX_ITEMS];
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (pool_size == '0) begin
      clamp_size = CNT_W'(1);
    end else if (pool_size > CNT_W'(MAX_ITEMS)) begin
      clamp_size = CNT_W'(MAX_ITEMS);
    end else begin
      clamp_size = pool_size;
    end
  end

  // reset loads the cells as a full pool of MAX_ITEMS
  assign load_size = rst ? CNT_W'(MAX_ITEMS) : clamp_size;

  // released item is still free when some live cell holds its index
  assign item_free = |on_stack;

  always_comb begin
    stack_top_next   = stack_top;
    active_size_next = active_size;
    status_next      = ST_OK;
    grant_next       = '0;
    cell_op          = CELL_HOLD;
    if (accept) begin
      unique case (cmd_t'(command))
        CMD_ACQUIRE: begin
          if (stack_top == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cell_op        = CELL_POP;
            stack_top_next = stack_top - CNT_W'(1);
            grant_next     = cell_q[0];
          end
        end
        CMD_RELEASE: begin
          if ({1'b0, item_index} >= active_size) begin
            status_next = ST_INVALID;
          end else if (item_free) begin
            status_next = ST_DOUBLE;
          end else if (stack_top < active_size) begin
            cell_op        = CELL_PUSH;
            stack_top_next = stack_top + CNT_W'(1);
          end else begin
            status_next = ST_OVERFLOW;
          end
        end
        CMD_RESTORE: begin
          cell_op          = CELL_LOAD;
          stack_top_next   = clamp_size;
          active_size_next = clamp_size;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= CNT_W'(MAX_ITEMS);
      active_size <= CNT_W'(MAX_ITEMS);
      stack_top   <= CNT_W'(MAX_ITEMS);
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_size <= cfg_wdata;
      end
      active_size <= active_size_next;
      stack_top   <= stack_top_next;
      done        <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status        <= status_next;
    granted_index <= grant_next;
  end

  assign available = stack_top;

  // Row of stack cells; slot j holds the entry j places below the top
  for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
    logic [IDX_W-1:0] above;
    logic [IDX_W-1:0] below;
    logic [IDX_W-1:0] load_value;

    // identity order: top of a pool of n is index n-1
    assign load_value = (CNT_W'(j) < load_size) ?
                        IDX_W'(load_size - CNT_W'(j) - CNT_W'(1)) : '0;

    assign on_stack[j] = (CNT_W'(j) < stack_top) && (cell_q[j] == item_index);

    if (j == 0) begin : g_top
      assign above = item_index;
    end else begin : g_mid
      assign above = cell_q[j-1];
    end

    if (j == MAX_ITEMS - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[j+1];
    end

    flsa_cell u_cell (
      .clk        (clk),
      .op         (rst ? CELL_LOAD : cell_op),
      .load_value (load_value),
      .above      (above),
      .below      (below),
      .value      (cell_q[j])
    );
  end

  a_top_bounded: assert property (@(posedge clk) disable iff (rst)
    stack_top <= active_size)
    else $error("stack top beyond active pool size");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("accepted command produced no result");

  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> granted_index == '0)
    else $error("nonzero grant on failed command");

  a_empty_at_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> available == '0)
    else $error("empty reported with free items left");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && (command == CMD_ACQUIRE) && (stack_top != '0)
    |=> stack_top == $past(stack_top) - CNT_W'(1))
    else $error("acquire did not pop exactly one entry");

endmodule

// ----- tb/free_list_stack_allocator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_stack_allocator_core_tb
// Runs acquire, release, restore and the unused command through the pool
// allocator under several pool sizes. A short directed table comes first, then
// random fill and drain traffic. Every response is checked against its pinned
// value or else an in-bench model of the free stack and out flags.
// ----------------------------------------------------------------------------
module free_list_stack_allocator_core_tb;
  import flsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int LIMIT = 200000;

  typedef struct packed {
    status_t            st;
    logic [IDX_W-1:0]   grant;
    logic [CNT_W-1:0]   avail;
  } alloc_resp_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   wdata;
    bit                 pinned;
    alloc_resp_t        res;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  // Pinned rows carry the response read straight off the spec
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd63, 7'd63}},
    '{ROW_CMD, CMD_RELEASE, 6'd63, 7'd0,   1'b1, '{ST_OK,      6'd0,  7'd64}},
    '{ROW_CMD, CMD_RELEASE, 6'd63, 7'd0,   1'b1, '{ST_DOUBLE,  6'd0,  7'd64}},
    '{ROW_CMD, CMD_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_DOUBLE,  6'd0,  7'd64}},
    '{ROW_CMD, CMD_NOP,     6'd63, 7'd0,   1'b1, '{ST_OK,      6'd0,  7'd64}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd21, 7'd0,   1'b1, '{ST_OK,      6'd63, 7'd63}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd42, 7'd0,   1'b1, '{ST_OK,      6'd62, 7'd62}},
    '{ROW_CMD, CMD_RELEASE, 6'd62, 7'd0,   1'b1, '{ST_OK,      6'd0,  7'd63}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b0, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_RESTORE, 6'd17, 7'd0,   1'b1, '{ST_OK,      6'd0,  7'd64}},
    // size 0 is taken as 1
    '{ROW_CFG, CMD_NOP,     6'd0,  7'd0,   1'b0, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_RESTORE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd1}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_EMPTY,   6'd0,  7'd0}},
    '{ROW_CMD, CMD_RELEASE, 6'd1,  7'd0,   1'b1, '{ST_INVALID, 6'd0,  7'd0}},
    '{ROW_CMD, CMD_RELEASE, 6'd63, 7'd0,   1'b1, '{ST_INVALID, 6'd0,  7'd0}},
    '{ROW_CMD, CMD_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd1}},
    '{ROW_CMD, CMD_RELEASE, 6'd0,  7'd0,   1'b1, '{ST_DOUBLE,  6'd0,  7'd1}},
    // oversize clamps to MAX_ITEMS, and only once restored
    '{ROW_CFG, CMD_NOP,     6'd0,  7'd127, 1'b0, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_RESTORE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd64}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd63, 7'd63}},
    '{ROW_CFG, CMD_NOP,     6'd0,  7'd3,   1'b0, '{ST_OK,      6'd0,  7'd0}},
    '{ROW_CMD, CMD_RESTORE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd0,  7'd3}},
    '{ROW_CMD, CMD_RELEASE, 6'd3,  7'd0,   1'b1, '{ST_INVALID, 6'd0,  7'd3}},
    '{ROW_CMD, CMD_ACQUIRE, 6'd0,  7'd0,   1'b1, '{ST_OK,      6'd2,  7'd2}}
  };

  int pool_plan [10] = '{1, 127, 0, 5, 33, 64, 2, 100, 17, 64};

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   command;
  logic [IDX_W-1:0]   item_index;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;
  logic               done;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]   granted_index;
  logic [CNT_W-1:0]   available;

  // pinned response travels with the command it belongs to
  logic               pin_valid;
  alloc_resp_t        pin_res;

  // allocator model state
  logic [IDX_W-1:0]   free_slots [MAX_ITEMS];
  bit                 item_out [MAX_ITEMS];
  int                 free_top;
  int                 live_size;
  int                 size_reg;

  alloc_resp_t        due_responses [$];
  int                 fail_count;
  int                 cycle_count;
  bit                 fill_mode;
  bit                 gaps_on;

  free_list_stack_allocator_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .item_index    (item_index),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .available     (available)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void refill_pool();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MAX_ITEMS) n = MAX_ITEMS;
    live_size = n;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      free_slots[i] = i[IDX_W-1:0];
      item_out[i] = 1'b0;
    end
    free_top = n;
  endfunction

  function automatic alloc_resp_t alloc_step(input logic [CMD_W-1:0] cmd,
                                             input logic [IDX_W-1:0] idx);
    alloc_resp_t r;
    r.st = ST_OK;
    r.grant = '0;
    case (cmd)
      CMD_ACQUIRE: begin
        if (free_top == 0) begin
          r.st = ST_EMPTY;
        end else begin
          free_top--;
          r.grant = free_slots[free_top];
          item_out[r.grant] = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (int'(idx) >= live_size) begin
          r.st = ST_INVALID;
        end else if (!item_out[idx]) begin
          r.st = ST_DOUBLE;
        end else if (free_top < live_size) begin
          item_out[idx] = 1'b0;
          free_slots[free_top] = idx;
          free_top++;
        end else begin
          r.st = ST_OVERFLOW;
        end
      end
      CMD_RESTORE: refill_pool();
      default: ;
    endcase
    r.avail = free_top[CNT_W-1:0];
    return r;
  endfunction

  // Response check first, then prediction of the transaction taken this edge
  always @(posedge clk) begin
    alloc_resp_t want;
    alloc_resp_t got;
    if (rst) begin
      size_reg = MAX_ITEMS;
      refill_pool();
    end else begin
      if (done) begin
        if (due_responses.size() == 0) begin
          $error("response with none pending: status %0d grant %0d avail %0d",
                 status, granted_index, available);
          fail_count++;
        end else begin
          want = due_responses.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
          if (granted_index !== want.grant) begin
            $error("granted_index: expected %0d, got %0d", want.grant, granted_index);
            fail_count++;
          end
          if (available !== want.avail) begin
            $error("available: expected %0d, got %0d", want.avail, available);
            fail_count++;
          end
        end
      end
      if (cfg_we) size_reg = int'(cfg_wdata);
      if (start && !busy) begin
        got = alloc_step(command, item_index);
        due_responses.push_back(pin_valid ? pin_res : got);
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                       input bit pinned, input alloc_resp_t res);
    command    <= cmd;
    item_index <= idx;
    pin_valid  <= pinned;
    pin_res    <= res;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // lower start, then hold until every pending response is back
  task automatic wait_quiet();
    start <= 1'b0;
    @(negedge clk);
    while (due_responses.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [CNT_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed acquire/release of items held out, plus some noise
  task automatic pick_random(output logic [CMD_W-1:0] cmd, output logic [IDX_W-1:0] idx);
    int held [$];
    int r;
    for (int i = 0; i < MAX_ITEMS; i++) if (item_out[i]) held.push_back(i);
    r = $urandom_range(999);
    idx = IDX_W'($urandom_range(MAX_ITEMS - 1));
    if (r < 15) begin
      cmd = CMD_NOP;
    end else if (r < 30) begin
      cmd = CMD_RESTORE;
    end else if (r < 110) begin
      cmd = CMD_RELEASE;
    end else if (held.size() == 0 || $urandom_range(99) < (fill_mode ? 70 : 25)) begin
      cmd = CMD_ACQUIRE;
    end else begin
      cmd = CMD_RELEASE;
      idx = IDX_W'(held[$urandom_range(held.size() - 1)]);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("free_list_stack_allocator_core verification failed");
    $finish;
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    int mode_left;
    rst        = 1'b1;
    start      = 1'b0;
    command    = '0;
    item_index = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    pin_valid  = 1'b0;
    pin_res    = '0;
    fail_count = 0;
    fill_mode  = 1'b1;
    gaps_on    = 1'b0;
    mode_left  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_pool_size(dir_rows[k].wdata);
      end else begin
        issue(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].pinned, dir_rows[k].res);
        if ($urandom_range(3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end

    foreach (pool_plan[p]) begin
      write_pool_size(CNT_W'(pool_plan[p]));
      issue(CMD_RESTORE, IDX_W'($urandom_range(MAX_ITEMS - 1)), 1'b0, '0);
      for (int n = 0; n < 185; n++) begin
        if (mode_left == 0) begin
          fill_mode = 1'($urandom_range(1));
          gaps_on   = (p == 9) ? 1'b0 : 1'($urandom_range(1));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        pick_random(cmd, idx);
        issue(cmd, idx, 1'b0, '0);
        if ($urandom_range(199) == 0 && p != 9) begin
          wait_quiet();
        end else if (gaps_on && $urandom_range(4) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (due_responses.size() != 0) begin
      $error("%0d responses never arrived", due_responses.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("free_list_stack_allocator_core verification clean");
    end else begin
      $display("free_list_stack_allocator_core verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/flsa_pkg.sv
rtl/flsa_cell.sv
rtl/free_list_stack_allocator_core.sv
tb/free_list_stack_allocator_core_tb.sv
